// ----- sv/ldgm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the LDGM parity encoder.
package ldgm_pkg;

    localparam int unsigned VAR_DEGREE   = 3;
    localparam int unsigned CHECK_DEGREE = 6;
    localparam int unsigned GROUPS       = 64;

    localparam int unsigned NUM_CHECKS = VAR_DEGREE * GROUPS;
    localparam int unsigned NUM_VARS   = CHECK_DEGREE * GROUPS;
    localparam int unsigned NUM_EDGES  = VAR_DEGREE * NUM_VARS;

    localparam int unsigned OP_W      = 2;
    localparam int unsigned ADDR_W    = 11;
    localparam int unsigned EDGE_W    = 11;
    localparam int unsigned CHK_IDX_W = 8;

    localparam int unsigned TBL_ADDR_W = $clog2(NUM_EDGES);
    localparam int unsigned VAR_ADDR_W = $clog2(NUM_VARS);
    localparam int unsigned CNT_W      = $clog2(CHECK_DEGREE + 1);

    localparam int unsigned DIV_SHIFT = EDGE_W + 4;
    localparam int unsigned DIV_RECIP = (2 ** DIV_SHIFT + VAR_DEGREE - 1) / VAR_DEGREE;
    localparam int unsigned RECIP_W   = DIV_SHIFT + 1;
    localparam int unsigned PROD_W    = EDGE_W + RECIP_W;

    localparam logic [OP_W-1:0] OP_LOAD_SOCKET = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_VAR    = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE     = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ADDR_W-1:0] address;
        logic [EDGE_W-1:0] value;
    } ldgm_in_t;

    typedef struct packed {
        logic [CHK_IDX_W-1:0] check_index;
        logic                 parity;
    } ldgm_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ldgm_state_t;

endpackage

// ----- sv/ldgm_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with one write port and a registered read port.
module ldgm_ram #(
    parameter int unsigned DEPTH  = 1024,
    parameter int unsigned WIDTH  = 8,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/ldgm_ctrl.sv -----
`timescale 1ns / 1ps
// Request decoder, parity sequencer and result register of the LDGM parity encoder.
module ldgm_ctrl import ldgm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ldgm_in_t              s_req,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ldgm_out_t             m_res,
    output logic                  tbl_we,
    output logic [TBL_ADDR_W-1:0] tbl_waddr,
    output logic [EDGE_W-1:0]     tbl_wdata,
    output logic [TBL_ADDR_W-1:0] tbl_raddr,
    input  logic [EDGE_W-1:0]     tbl_rdata,
    output logic                  var_we,
    output logic [VAR_ADDR_W-1:0] var_waddr,
    output logic [0:0]            var_wdata,
    output logic [VAR_ADDR_W-1:0] var_raddr,
    input  logic [0:0]            var_rdata
);

    ldgm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [TBL_ADDR_W-1:0] base_reg, base_next;
    logic [CHK_IDX_W-1:0] chk_reg, chk_next;
    logic                 parity_reg, parity_next;
    logic                 p1_vld_reg, p1_vld_next;
    logic                 p2_vld_reg, p2_vld_next;
    logic                 p2_en_reg, p2_en_next;
    logic [PROD_W-1:0]    p2_prod_reg, p2_prod_next;
    logic                 p3_vld_reg, p3_vld_next;
    logic                 p3_en_reg, p3_en_next;
    logic                 m_valid_reg, m_valid_next;
    ldgm_out_t            m_res_reg, m_res_next;
    logic                 accept;
    logic                 edge_ok;
    logic [EDGE_W-1:0]    edge_m1;

    assign accept  = s_valid && s_ready;
    assign edge_ok = (tbl_rdata != '0) && (32'(tbl_rdata) <= NUM_EDGES);
    assign edge_m1 = tbl_rdata - EDGE_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            p1_vld_reg  <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p3_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            p1_vld_reg  <= p1_vld_next;
            p2_vld_reg  <= p2_vld_next;
            p3_vld_reg  <= p3_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg     <= cnt_next;
        base_reg    <= base_next;
        chk_reg     <= chk_next;
        parity_reg  <= parity_next;
        p2_en_reg   <= p2_en_next;
        p2_prod_reg <= p2_prod_next;
        p3_en_reg   <= p3_en_next;
        m_res_reg   <= m_res_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        base_next    = base_reg;
        chk_next     = chk_reg;
        parity_next  = parity_reg;
        p1_vld_next  = 1'b0;
        p2_vld_next  = p1_vld_reg;
        p2_en_next   = edge_ok;
        p2_prod_next = PROD_W'(edge_m1) * PROD_W'(DIV_RECIP);
        p3_vld_next  = p2_vld_reg;
        p3_en_next   = p2_en_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_res_next   = m_res_reg;
        s_ready      = 1'b0;
        tbl_we       = 1'b0;
        tbl_waddr    = s_req.address[TBL_ADDR_W-1:0];
        tbl_wdata    = s_req.value;
        tbl_raddr    = base_reg + TBL_ADDR_W'(cnt_reg);
        var_we       = 1'b0;
        var_waddr    = s_req.address[VAR_ADDR_W-1:0];
        var_wdata    = s_req.value[0:0];
        var_raddr    = p2_prod_reg[DIV_SHIFT +: VAR_ADDR_W];

        if (p3_vld_reg) begin
            parity_next = parity_reg ^ (var_rdata[0] & p3_en_reg);
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    unique case (s_req.operation)
                        OP_LOAD_SOCKET: begin
                            tbl_we = 32'(s_req.address) < NUM_EDGES;
                        end
                        OP_LOAD_VAR: begin
                            var_we = 32'(s_req.address) < NUM_VARS;
                        end
                        OP_COMPUTE: begin
                            if (32'(s_req.address) < NUM_CHECKS) begin
                                base_next   = TBL_ADDR_W'(32'(s_req.address) * CHECK_DEGREE);
                                chk_next    = s_req.address[CHK_IDX_W-1:0];
                                cnt_next    = '0;
                                parity_next = 1'b0;
                                state_next  = ST_RUN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                if (32'(cnt_reg) < CHECK_DEGREE) begin
                    p1_vld_next = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end else if (!p1_vld_reg && !p2_vld_reg && !p3_vld_reg) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_res_next.check_index = chk_reg;
                    m_res_next.parity      = parity_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

endmodule

// ----- sv/ldgm_parity_encoder_core.sv -----
`timescale 1ns / 1ps
// Top level of the LDGM parity encoder: sequencer and the two state memories.
//
// Load requests (connection socket or variable bit) are taken while idle and
// written straight into the connection-table RAM or the variable-bit RAM. A compute
// request reads the CHECK_DEGREE table entries of one check node, one per cycle from
// the single read port of the connection table, turns each edge number into its
// variable index and reads that bit from the variable RAM, accumulating the XOR.
// A compute closes the input while it issues the CHECK_DEGREE table reads, while the
// read and multiply stages behind them drain and while it loads the result register.
// The result sits in an output register, so the next request is taken while it
// waits; only when a further compute finishes before that result is taken does the
// input stay closed until the output register is free. Neither memory is cleared
// after reset: entries must be written before they are read.
module ldgm_parity_encoder_core import ldgm_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  ldgm_in_t  s_req,
    output logic      m_valid,
    input  logic      m_ready,
    output ldgm_out_t m_res
);

    logic                  tbl_we;
    logic [TBL_ADDR_W-1:0] tbl_waddr;
    logic [EDGE_W-1:0]     tbl_wdata;
    logic [TBL_ADDR_W-1:0] tbl_raddr;
    logic [EDGE_W-1:0]     tbl_rdata;
    logic                  var_we;
    logic [VAR_ADDR_W-1:0] var_waddr;
    logic [0:0]            var_wdata;
    logic [VAR_ADDR_W-1:0] var_raddr;
    logic [0:0]            var_rdata;

    ldgm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata),
        .var_we    (var_we),
        .var_waddr (var_waddr),
        .var_wdata (var_wdata),
        .var_raddr (var_raddr),
        .var_rdata (var_rdata)
    );

    ldgm_ram #(
        .DEPTH  (NUM_EDGES),
        .WIDTH  (EDGE_W),
        .ADDR_W (TBL_ADDR_W)
    ) u_tbl_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    ldgm_ram #(
        .DEPTH  (NUM_VARS),
        .WIDTH  (1),
        .ADDR_W (VAR_ADDR_W)
    ) u_var_ram (
        .aclk  (aclk),
        .we    (var_we),
        .waddr (var_waddr),
        .wdata (var_wdata),
        .raddr (var_raddr),
        .rdata (var_rdata)
    );

`ifndef SYNTH
    // Memories are written only by an accepted load request, never during a compute.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (tbl_we || var_we) |-> (s_valid && s_ready))
        else $error("memory write without an accepted load request");

    // An in-range compute request closes the input until its result is produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_req.operation == OP_COMPUTE
         && 32'(s_req.address) < NUM_CHECKS) |=> !s_ready)
        else $error("input still open after a compute request");

    // A result only appears at the end of a compute, while the input is closed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result produced without a compute in progress");

    // Both memories cannot be written by the same request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(tbl_we && var_we))
        else $error("both memories written in one cycle");
`endif

endmodule
